>>> rtl/assert_macros.svh
// assertion helpers for the bar scanner block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lbss_pkg.sv
package lbss_pkg;

  localparam int NUM_BARS = 8;
  localparam int CNT_W    = $clog2(NUM_BARS + 1);
  localparam int IDX_W    = $clog2(NUM_BARS);
  localparam int RND_W    = 16;
  localparam int PC_W     = 4;

  localparam logic [1:0] MODE_BOUNCE = 2'd0;
  localparam logic [1:0] MODE_PULSE  = 2'd1;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_RED   = 2'd1;
  localparam logic [1:0] CFG_GREEN = 2'd2;
  localparam logic [1:0] CFG_BLUE  = 2'd3;

  localparam logic [4:0] SPEED_SLOW = 5'd5;
  localparam logic [4:0] SPEED_FAST = 5'd20;
  localparam logic [7:0] LEVEL_FULL = 8'd255;

  // microcode addresses
  localparam logic [PC_W-1:0] A_BLK   = 4'd0;
  localparam logic [PC_W-1:0] A_MODE  = 4'd1;
  localparam logic [PC_W-1:0] A_SBNC  = 4'd2;
  localparam logic [PC_W-1:0] A_PLS0  = 4'd3;
  localparam logic [PC_W-1:0] A_PUP_A = 4'd4;
  localparam logic [PC_W-1:0] A_PUP_B = 4'd5;
  localparam logic [PC_W-1:0] A_PDN_A = 4'd6;
  localparam logic [PC_W-1:0] A_PDN_B = 4'd7;
  localparam logic [PC_W-1:0] A_PEND  = 4'd8;
  localparam logic [PC_W-1:0] A_BNC_A = 4'd9;
  localparam logic [PC_W-1:0] A_BNC_B = 4'd10;
  localparam logic [PC_W-1:0] A_TGL   = 4'd11;
  localparam logic [PC_W-1:0] A_DONE  = 4'd12;

  typedef struct packed {
    logic             action;
    logic [RND_W-1:0] random_bits;
  } lbss_in_t;

  typedef struct packed {
    logic       bank;
    logic [2:0] header;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [4:0] fade_speed;
    logic       is_fade;
    logic       last;
  } lbss_out_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lbss_cfg_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_BLACK,
    EM_FADE_IN,
    EM_FADE_OUT,
    EM_QUARTER,
    EM_TOGGLE
  } lbss_emit_e;

  typedef enum logic [2:0] {
    BS_BLK,
    BS_CNT,
    BS_IDX,
    BS_POS,
    BS_ONE
  } lbss_bar_sel_e;

  typedef enum logic [1:0] {
    CN_HOLD,
    CN_LOAD,
    CN_INC,
    CN_DEC
  } lbss_cnt_op_e;

  typedef enum logic [1:0] {
    PO_HOLD,
    PO_START,
    PO_BOUNCE
  } lbss_pos_op_e;

  typedef enum logic [1:0] {
    LS_NEVER,
    LS_ALWAYS,
    LS_BLK,
    LS_TOGGLE
  } lbss_last_sel_e;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_LOOP,
    BR_MODE,
    BR_END
  } lbss_branch_e;

  typedef struct packed {
    lbss_emit_e       emit;
    lbss_bar_sel_e    bar;
    logic             fast;
    lbss_cnt_op_e     cnt_op;
    logic [CNT_W-1:0] cnt_val;
    logic [CNT_W-1:0] limit;
    lbss_pos_op_e     pos_op;
    lbss_last_sel_e   last_sel;
    lbss_branch_e     branch;
    logic [PC_W-1:0]  target;
  } lbss_uword_t;

  typedef struct packed {
    logic step;
    logic dispatch;
    logic clear_lit;
  } lbss_dp_ctrl_t;

  typedef struct packed {
    logic      emit_valid;
    logic      at_limit;
    lbss_out_t item;
  } lbss_dp_stat_t;

  function automatic logic is_toggle(input logic [1:0] mode);
    return (mode != MODE_BOUNCE) && (mode != MODE_PULSE);
  endfunction

  // blackout order: header by header, bank by bank
  function automatic logic [CNT_W-1:0] blk_bar(input logic [IDX_W-1:0] j);
    logic [CNT_W-1:0] bar;
    int n;
    int h;
    int k;
    bar = '0;
    n = 0;
    for (h = 0; h < 4; h++) begin
      for (k = 0; k < NUM_BARS; k++) begin
        if (k * 4 + h + 1 <= NUM_BARS) begin
          if (n == int'(j)) begin
            bar = CNT_W'(k * 4 + h + 1);
          end
          n = n + 1;
        end
      end
    end
    return bar;
  endfunction

  // bars whose random field is zero
  function automatic logic [NUM_BARS-1:0] zero_fields(input logic [RND_W-1:0] rnd);
    logic [NUM_BARS-1:0] z;
    int i;
    z = '1;
    for (i = 0; i < NUM_BARS; i++) begin
      if (2 * i + 1 < RND_W) begin
        z[i] = (rnd[2*i +: 2] == 2'b00);
      end
    end
    return z;
  endfunction

endpackage

>>> rtl/lbss_ucode_rom.sv
module lbss_ucode_rom (
  input  logic [lbss_pkg::PC_W-1:0] pc_i,
  output lbss_pkg::lbss_uword_t     uword_o
);
  import lbss_pkg::*;

  localparam logic [CNT_W-1:0] C_ZERO = '0;
  localparam logic [CNT_W-1:0] C_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] C_TOP  = CNT_W'(NUM_BARS);
  localparam logic [CNT_W-1:0] C_LAST = CNT_W'(NUM_BARS - 1);

  function automatic lbss_uword_t mk(
    input lbss_emit_e       em,
    input lbss_bar_sel_e    bs,
    input logic             fast,
    input lbss_cnt_op_e     co,
    input logic [CNT_W-1:0] val,
    input logic [CNT_W-1:0] lim,
    input lbss_pos_op_e     po,
    input lbss_last_sel_e   ls,
    input lbss_branch_e     br,
    input logic [PC_W-1:0]  tgt
  );
    lbss_uword_t w;
    w.emit     = em;
    w.bar      = bs;
    w.fast     = fast;
    w.cnt_op   = co;
    w.cnt_val  = val;
    w.limit    = lim;
    w.pos_op   = po;
    w.last_sel = ls;
    w.branch   = br;
    w.target   = tgt;
    return w;
  endfunction

  always_comb begin
    unique case (pc_i)
      A_BLK:   uword_o = mk(EM_BLACK, BS_BLK, 1'b0, CN_INC, C_ZERO, C_LAST,
                            PO_HOLD, LS_BLK, BR_LOOP, A_BLK);
      A_MODE:  uword_o = mk(EM_NONE, BS_ONE, 1'b0, CN_LOAD, C_ZERO, C_ZERO,
                            PO_HOLD, LS_NEVER, BR_MODE, A_DONE);
      A_SBNC:  uword_o = mk(EM_FADE_IN, BS_ONE, 1'b0, CN_HOLD, C_ZERO, C_ZERO,
                            PO_START, LS_ALWAYS, BR_END, A_DONE);
      A_PLS0:  uword_o = mk(EM_FADE_IN, BS_ONE, 1'b1, CN_LOAD, C_TWO, C_ZERO,
                            PO_HOLD, LS_NEVER, BR_NEXT, A_DONE);
      A_PUP_A: uword_o = mk(EM_FADE_IN, BS_CNT, 1'b0, CN_HOLD, C_ZERO, C_ZERO,
                            PO_HOLD, LS_NEVER, BR_NEXT, A_DONE);
      A_PUP_B: uword_o = mk(EM_BLACK, BS_CNT, 1'b0, CN_INC, C_LAST, C_TOP,
                            PO_HOLD, LS_NEVER, BR_LOOP, A_PUP_A);
      A_PDN_A: uword_o = mk(EM_FADE_IN, BS_CNT, 1'b0, CN_HOLD, C_ZERO, C_ZERO,
                            PO_HOLD, LS_NEVER, BR_NEXT, A_DONE);
      A_PDN_B: uword_o = mk(EM_BLACK, BS_CNT, 1'b0, CN_DEC, C_ZERO, C_TWO,
                            PO_HOLD, LS_NEVER, BR_LOOP, A_PDN_A);
      A_PEND:  uword_o = mk(EM_QUARTER, BS_ONE, 1'b1, CN_HOLD, C_ZERO, C_ZERO,
                            PO_HOLD, LS_ALWAYS, BR_END, A_DONE);
      A_BNC_A: uword_o = mk(EM_FADE_OUT, BS_POS, 1'b0, CN_HOLD, C_ZERO, C_ZERO,
                            PO_BOUNCE, LS_NEVER, BR_NEXT, A_DONE);
      A_BNC_B: uword_o = mk(EM_FADE_IN, BS_POS, 1'b0, CN_HOLD, C_ZERO, C_ZERO,
                            PO_HOLD, LS_ALWAYS, BR_END, A_DONE);
      A_TGL:   uword_o = mk(EM_TOGGLE, BS_IDX, 1'b0, CN_INC, C_ZERO, C_LAST,
                            PO_HOLD, LS_TOGGLE, BR_LOOP, A_TGL);
      default: uword_o = mk(EM_NONE, BS_ONE, 1'b0, CN_HOLD, C_ZERO, C_ZERO,
                            PO_HOLD, LS_NEVER, BR_END, A_DONE);
    endcase
  end

endmodule

>>> rtl/lbss_datapath.sv
module lbss_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lbss_pkg::lbss_uword_t      uword_i,
  input  lbss_pkg::lbss_dp_ctrl_t    ctrl_i,
  input  lbss_pkg::lbss_cfg_t        cfg_i,
  input  logic [lbss_pkg::RND_W-1:0] rnd_i,
  output lbss_pkg::lbss_dp_stat_t    stat_o
);
  import lbss_pkg::*;

  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic                up_q, up_d;
  logic [NUM_BARS-1:0] lit_q, lit_d;
  logic [RND_W-1:0]    rnd_q;

  logic [IDX_W-1:0]    idx;
  logic [NUM_BARS-1:0] zmask;
  logic                z_here;
  logic                z_above;
  logic [CNT_W-1:0]    bar;
  logic [CNT_W-1:0]    bar_m1;
  logic                in_range;
  logic [7:0]          eff_red;
  logic                at_limit;
  lbss_out_t           item;
  logic                emit_valid;

  assign idx      = cnt_q[IDX_W-1:0];
  assign zmask    = zero_fields(rnd_q);
  assign z_here   = zmask[idx];
  assign at_limit = (cnt_q == uword_i.limit);
  assign eff_red  = ((cfg_i.red | cfg_i.green | cfg_i.blue) == 8'd0) ? LEVEL_FULL
                                                                      : cfg_i.red;

  always_comb begin
    z_above = 1'b0;
    for (int i = 0; i < NUM_BARS; i++) begin
      if (zmask[i] && (i > int'(cnt_q))) begin
        z_above = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (uword_i.bar)
      BS_BLK:  bar = blk_bar(idx);
      BS_CNT:  bar = cnt_q;
      BS_IDX:  bar = cnt_q + CNT_W'(1);
      BS_POS:  bar = pos_q;
      BS_ONE:  bar = CNT_W'(1);
      default: bar = '0;
    endcase
  end

  assign in_range = (bar != '0) && (bar <= CNT_W'(NUM_BARS));
  assign bar_m1   = bar - CNT_W'(1);

  always_comb begin
    item            = '0;
    item.bank       = bar_m1[2];
    item.header     = {1'b0, bar_m1[1:0]} + 3'd1;
    item.fade_speed = uword_i.fast ? SPEED_FAST : SPEED_SLOW;
    item.is_fade    = 1'b1;
    unique case (uword_i.emit)
      EM_BLACK: begin
        item.fade_speed = 5'd0;
        item.is_fade    = 1'b0;
      end
      EM_FADE_IN: begin
        item.out_red   = eff_red;
        item.out_green = cfg_i.green;
        item.out_blue  = cfg_i.blue;
      end
      EM_QUARTER: begin
        item.out_red   = {2'b00, eff_red[7:2]};
        item.out_green = {2'b00, cfg_i.green[7:2]};
        item.out_blue  = {2'b00, cfg_i.blue[7:2]};
      end
      EM_TOGGLE: begin
        if (!lit_q[idx]) begin
          item.out_red   = eff_red;
          item.out_green = cfg_i.green;
          item.out_blue  = cfg_i.blue;
        end
      end
      default: begin
      end
    endcase
    unique case (uword_i.last_sel)
      LS_ALWAYS: item.last = 1'b1;
      LS_BLK:    item.last = (cnt_q == CNT_W'(NUM_BARS - 1)) && is_toggle(cfg_i.mode)
                             && (zmask == '0);
      LS_TOGGLE: item.last = !z_above;
      default:   item.last = 1'b0;
    endcase
  end

  assign emit_valid = (uword_i.emit != EM_NONE) && in_range
                      && ((uword_i.emit != EM_TOGGLE) || z_here);

  assign stat_o.emit_valid = emit_valid;
  assign stat_o.at_limit   = at_limit;
  assign stat_o.item       = item;

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    up_d  = up_q;
    lit_d = lit_q;
    if (ctrl_i.dispatch) begin
      cnt_d = '0;
      if (ctrl_i.clear_lit) begin
        lit_d = '0;
      end
    end else if (ctrl_i.step) begin
      if ((uword_i.branch == BR_LOOP) && at_limit) begin
        cnt_d = uword_i.cnt_val;
      end else begin
        unique case (uword_i.cnt_op)
          CN_HOLD: cnt_d = cnt_q;
          CN_LOAD: cnt_d = uword_i.cnt_val;
          CN_INC:  cnt_d = cnt_q + CNT_W'(1);
          CN_DEC:  cnt_d = cnt_q - CNT_W'(1);
          default: cnt_d = cnt_q;
        endcase
      end
      unique case (uword_i.pos_op)
        PO_START: begin
          pos_d = CNT_W'(1);
          up_d  = 1'b1;
        end
        PO_BOUNCE: begin
          if (pos_q <= CNT_W'(1)) begin
            pos_d = CNT_W'(2);
            up_d  = 1'b1;
          end else if (pos_q >= CNT_W'(NUM_BARS)) begin
            pos_d = CNT_W'(NUM_BARS - 1);
            up_d  = 1'b0;
          end else if (up_q) begin
            pos_d = pos_q + CNT_W'(1);
          end else begin
            pos_d = pos_q - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
      if ((uword_i.emit == EM_TOGGLE) && z_here) begin
        lit_d[idx] = !lit_q[idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
      up_q  <= 1'b0;
      lit_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      up_q  <= up_d;
      lit_q <= lit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.dispatch) begin
      rnd_q <= rnd_i;
    end
  end

endmodule

>>> rtl/led_bar_scanner_sequencer.sv
// one microcode step per cycle while the output is not stalled, each step emits at most one command
// a result reaches the output register in the cycle after its step; an item runs as microcode steps
// after the accept cycle (a start in pulse mode is longest); the next item is taken once the
// sequencer reaches its end step or emits an item marked last, and a stalled output holds the step that emits
// reset clears the config, control and valid registers, bar position, direction and all lit flags
module led_bar_scanner_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lbss_pkg::lbss_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lbss_pkg::lbss_out_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [7:0]           cfg_data_i
);
  import lbss_pkg::*;

  `include "assert_macros.svh"

  lbss_cfg_t       cfg_q, cfg_d;
  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            out_valid_q, out_valid_d;
  lbss_out_t       out_data_q;

  lbss_uword_t     uword;
  lbss_dp_ctrl_t   dp_ctrl;
  lbss_dp_stat_t   dp_stat;
  logic            accept;
  logic            emit;
  logic            step_en;
  logic            done;
  logic [PC_W-1:0] entry_pc;
  logic [PC_W-1:0] mode_pc;

  assign in_ready_o  = !busy_q;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign emit        = busy_q && dp_stat.emit_valid;
  assign step_en     = busy_q && (!dp_stat.emit_valid || !out_valid_q || out_ready_i);
  assign done        = (uword.branch == BR_END) || (emit && dp_stat.item.last);

  always_comb begin
    priority if (cfg_q.mode == MODE_BOUNCE) begin
      mode_pc = A_SBNC;
    end else if (cfg_q.mode == MODE_PULSE) begin
      mode_pc = A_PLS0;
    end else begin
      mode_pc = A_TGL;
    end
  end

  always_comb begin
    priority if (!in_data_i.action) begin
      entry_pc = A_BLK;
    end else if (cfg_q.mode == MODE_BOUNCE) begin
      entry_pc = A_BNC_A;
    end else if (cfg_q.mode == MODE_PULSE) begin
      entry_pc = A_PLS0;
    end else begin
      entry_pc = A_TGL;
    end
  end

  assign dp_ctrl.step      = step_en;
  assign dp_ctrl.dispatch  = accept;
  assign dp_ctrl.clear_lit = accept && !in_data_i.action && is_toggle(cfg_q.mode);

  lbss_ucode_rom u_rom (
    .pc_i    (pc_q),
    .uword_o (uword)
  );

  lbss_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .uword_i (uword),
    .ctrl_i  (dp_ctrl),
    .cfg_i   (cfg_q),
    .rnd_i   (in_data_i.random_bits),
    .stat_o  (dp_stat)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODE:  cfg_d.mode  = cfg_data_i[1:0];
        CFG_RED:   cfg_d.red   = cfg_data_i;
        CFG_GREEN: cfg_d.green = cfg_data_i;
        CFG_BLUE:  cfg_d.blue  = cfg_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = entry_pc;
    end else if (step_en) begin
      if (done) begin
        busy_d = 1'b0;
      end
      unique case (uword.branch)
        BR_NEXT: pc_d = pc_q + PC_W'(1);
        BR_LOOP: pc_d = dp_stat.at_limit ? pc_q + PC_W'(1) : uword.target;
        BR_MODE: pc_d = mode_pc;
        BR_END:  pc_d = pc_q;
        default: pc_d = pc_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_en && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      busy_q      <= 1'b0;
      pc_q        <= A_DONE;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && emit) begin
      out_data_q <= dp_stat.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy_q, "accepted item did not start the sequencer")
  `ASSERT_IMPLIES(a_pc_range, clk_i, rst_ni, busy_q, pc_q <= A_DONE, "step counter left the program")
  `ASSERT_IMPLIES(a_header_range, clk_i, rst_ni, out_valid_o, (out_data_o.header != 3'd0) && (out_data_o.header <= 3'd4), "header out of range")

endmodule
